FILE: hdl/cgp_pkg.sv
// Shared types and constants for the cosine grating pixel generator.
package cgp_pkg;

   // register map, indexed by paddr[3:2]
   localparam logic [1:0] REG_SIZE   = 2'd0;
   localparam logic [1:0] REG_FREQ   = 2'd1;
   localparam logic [1:0] REG_ORIENT = 2'd2;

   localparam int DEF_MAX_SIZE = 1024;
   localparam int SIZE_W       = 11;
   localparam int FREQ_W       = 9;
   localparam int COORD_W      = 10;
   localparam int PROD_W       = FREQ_W + COORD_W;
   localparam int FRAC_W       = 16;
   localparam int PIXEL_W      = 8;

   // Horner accumulator width (signed Q30 plus headroom)
   localparam int ACC_W = 34;
   localparam logic signed [ACC_W-1:0] Q30_ONE = 34'sd1073741824;
   localparam logic signed [ACC_W-1:0] COS_C1  = 34'sd1324675879;
   localparam logic signed [ACC_W-1:0] COS_C2  = 34'sd272375560;
   localparam logic signed [ACC_W-1:0] COS_C3  = 34'sd22401992;
   localparam logic signed [ACC_W-1:0] COS_C4  = 34'sd987048;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd256;
   localparam logic [FREQ_W-1:0] FREQ_RESET = 9'd1;

   typedef struct packed {
      logic [SIZE_W-1:0] image_size;
      logic [FREQ_W-1:0] frequency;
      logic              orientation;
   } csr_type;

endpackage

FILE: hdl/cosine_grating_pixel.sv
// Top level of the cosine grating test pattern pixel generator.
//
//  channel  direction  payload
//  req      in         tdata[9:0] row, tdata[19:10] col
//  rsp      out        tdata[7:0] pixel
//  csr      in/out     APB, 0x0 image_size, 0x4 frequency, 0x8 orientation
//
// One item per clock sustained while rsp_tready is high; the pipeline is the front
// register, the two bit-per-stage dividers and the cosine stages.
// Reset is synchronous and clears all valid bits; registers return to defaults.
// Each stage holds only while it carries an item the next cannot take, so
// bubbles collapse and a stalled output still lets new items enter.
module cosine_grating_pixel #(
   parameter int MAX_SIZE = cgp_pkg::DEF_MAX_SIZE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // row[9:0], col[19:10], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // pixel[7:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import cgp_pkg::*;

   localparam int NW  = $clog2(MAX_SIZE + 1);
   localparam int DW2 = NW + FRAC_W;

   csr_type cfg;

   cgp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // effective size, clamped to 1..MAX_SIZE
   logic [NW-1:0] n;
   always_comb begin
      priority if (cfg.image_size == '0) begin
         n = NW'(1);
      end else if (32'(cfg.image_size) > MAX_SIZE) begin
         n = NW'(MAX_SIZE);
      end else begin
         n = NW'(cfg.image_size);
      end
   end

   // front stage: wave index times frequency
   logic              f_v_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [COORD_W-1:0] idx;
   logic              div1_ready;

   assign idx        = cfg.orientation ? req_tdata[9:0] : req_tdata[19:10];
   assign prod_in    = PROD_W'(cfg.frequency * idx);
   assign req_tready = !f_v_ff || div1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (req_tready) begin
         f_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) prod_ff <= prod_in;
   end

   // phase = product mod N
   logic              d1_valid, div2_ready;
   logic [PROD_W-1:0] d1_quot;
   logic [NW-1:0]     phase;

   cgp_div #(.DW(PROD_W), .NW(NW)) u_mod (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (f_v_ff),
      .in_ready    (div1_ready),
      .in_dividend (prod_ff),
      .divisor     (n),
      .out_valid   (d1_valid),
      .out_ready   (div2_ready),
      .out_quot    (d1_quot),
      .out_rem     (phase)
   );

   // frac = (phase * 65536 + N/2) / N
   logic [DW2-1:0] dividend2;
   logic           d2_valid, cos_ready;
   logic [DW2-1:0] d2_quot;
   logic [NW-1:0]  d2_rem;
   logic [NW-1:0]  unused_rem;

   assign dividend2  = {phase, {FRAC_W{1'b0}}} + DW2'(n >> 1);
   assign unused_rem = d2_rem ^ NW'(d1_quot);

   cgp_div #(.DW(DW2), .NW(NW)) u_frac (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (d1_valid),
      .in_ready    (div2_ready),
      .in_dividend (dividend2),
      .divisor     (n),
      .out_valid   (d2_valid),
      .out_ready   (cos_ready),
      .out_quot    (d2_quot),
      .out_rem     (d2_rem)
   );

   cgp_cos u_cos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d2_valid),
      .in_ready  (cos_ready),
      .in_frac   (d2_quot[FRAC_W-1:0]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (rsp_tdata)
   );

endmodule

FILE: hdl/cgp_csr.sv
// APB register file holding image size, frequency and orientation.
module cgp_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output cgp_pkg::csr_type cfg
);
   import cgp_pkg::*;

   logic [SIZE_W-1:0] size_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic              orient_ff;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= SIZE_RESET;
         freq_ff   <= FREQ_RESET;
         orient_ff <= 1'b0;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_SIZE:   size_ff   <= csr_pwdata[SIZE_W-1:0];
            REG_FREQ:   freq_ff   <= csr_pwdata[FREQ_W-1:0];
            REG_ORIENT: orient_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SIZE:   csr_prdata = {{(32-SIZE_W){1'b0}}, size_ff};
         REG_FREQ:   csr_prdata = {{(32-FREQ_W){1'b0}}, freq_ff};
         REG_ORIENT: csr_prdata = {31'd0, orient_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   assign cfg.image_size  = size_ff;
   assign cfg.frequency   = freq_ff;
   assign cfg.orientation = orient_ff;

endmodule

FILE: hdl/cgp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cgp_div #(
   parameter int DW = 19,
   parameter int NW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [DW-1:0] in_dividend,
   input  logic [NW-1:0] divisor,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [DW-1:0] out_quot,
   output logic [NW-1:0] out_rem
);
   logic          v_ff [DW];
   logic [NW-1:0] r_ff [DW];
   logic [DW-1:0] q_ff [DW];
   logic [DW-1:0] d_ff [DW];
   logic          adv  [DW+1];

   assign adv[DW]   = out_ready;
   assign in_ready  = adv[0];
   assign out_valid = v_ff[DW-1];
   assign out_quot  = q_ff[DW-1];
   assign out_rem   = r_ff[DW-1];

   for (genvar s = 0; s < DW; s++) begin : g_stage
      logic          pv;
      logic [NW-1:0] pr;
      logic [DW-1:0] pq, pd;
      logic [NW:0]   t;
      logic          ge;
      logic [NW-1:0] r_in;
      logic [DW-1:0] q_in, d_in;

      if (s == 0) begin : g_first
         assign pv = in_valid;
         assign pr = '0;
         assign pq = '0;
         assign pd = in_dividend;
      end else begin : g_next
         assign pv = v_ff[s-1];
         assign pr = r_ff[s-1];
         assign pq = q_ff[s-1];
         assign pd = d_ff[s-1];
      end

      // stage stalls only when holding an item the next stage cannot take
      assign adv[s] = !v_ff[s] || adv[s+1];

      // shift in next dividend bit, subtract divisor when it fits
      assign t    = {pr, pd[DW-1]};
      assign ge   = t >= {1'b0, divisor};
      assign r_in = ge ? NW'(t - {1'b0, divisor}) : t[NW-1:0];
      assign q_in = DW'({pq, ge});
      assign d_in = DW'({pd, 1'b0});

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            v_ff[s] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            r_ff[s] <= r_in;
            q_ff[s] <= q_in;
            d_ff[s] <= d_in;
         end
      end
   end

endmodule

FILE: hdl/cgp_cos.sv
// Quarter-wave polynomial cosine and pixel mapping, seven register stages.
module cgp_cos (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [cgp_pkg::FRAC_W-1:0]    in_frac,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [cgp_pkg::PIXEL_W-1:0]   out_pixel
);
   import cgp_pkg::*;

   logic v_ff [7];
   logic adv  [8];

   logic [1:0]              quad_ff  [6];
   logic [14:0]             u_ff;
   logic [30:0]             x2_ff    [2:4];
   logic signed [ACC_W-1:0] acc_ff   [2:5];
   logic [PIXEL_W-1:0]      pixel_ff;

   assign adv[7]    = out_ready;
   assign in_ready  = adv[0];
   assign out_valid = v_ff[6];
   assign out_pixel = pixel_ff;

   for (genvar s = 0; s < 7; s++) begin : g_ctl
      assign adv[s] = !v_ff[s] || adv[s+1];
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            v_ff[s] <= (s == 0) ? in_valid : v_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   // stage 0: quadrant and reflected offset
   logic [1:0]  quad_in;
   logic [14:0] u_in;
   always_comb begin
      quad_in = in_frac[15:14];
      if (quad_in[0]) begin
         u_in = 15'd16384 - {1'b0, in_frac[13:0]};
      end else begin
         u_in = {1'b0, in_frac[13:0]};
      end
   end

   // stage 1: x^2 in Q30
   logic [29:0] u_sq;
   logic [30:0] x2_in;
   logic [30:0] x2_1_ff;
   assign u_sq  = 30'(u_ff) * 30'(u_ff);
   assign x2_in = {u_sq[28:0], 2'b00};

   // stages 2..5: Horner steps
   logic signed [ACC_W-1:0] x2s1, x2s2, x2s3, x2s4;
   logic signed [65:0]      p2, p3, p4, p5;
   logic signed [ACC_W-1:0] acc2_in, acc3_in, acc4_in, acc5_in;
   assign x2s1 = ACC_W'({1'b0, x2_1_ff});
   assign x2s2 = ACC_W'({1'b0, x2_ff[2]});
   assign x2s3 = ACC_W'({1'b0, x2_ff[3]});
   assign x2s4 = ACC_W'({1'b0, x2_ff[4]});

   assign p2 = 66'(COS_C4 * x2s1);
   assign acc2_in = COS_C3 - ACC_W'(p2 >>> 30);
   assign p3 = 66'(acc_ff[2] * x2s2);
   assign acc3_in = COS_C2 - ACC_W'(p3 >>> 30);
   assign p4 = 66'(acc_ff[3] * x2s3);
   always_comb begin
      acc4_in = COS_C1 - ACC_W'(p4 >>> 30);
      if (acc4_in < 0) acc4_in = '0;
   end
   assign p5 = 66'(acc_ff[4] * x2s4);
   always_comb begin
      acc5_in = Q30_ONE - ACC_W'(p5 >>> 30);
      if (acc5_in < 0) acc5_in = '0;
      if (acc5_in > Q30_ONE) acc5_in = Q30_ONE;
   end

   // stage 6: Q1.15 rounding, sign and grey mapping
   logic [16:0]        c_mag;
   logic signed [17:0] c_s;
   logic signed [17:0] t_s;
   logic [PIXEL_W-1:0] pixel_in;
   always_comb begin
      c_mag = 17'((acc_ff[5] + 34'sd16384) >>> 15);
      if (c_mag > 17'd32767) c_mag = 17'd32767;
      if (quad_ff[5] == 2'd1 || quad_ff[5] == 2'd2) begin
         c_s = -$signed({1'b0, c_mag});
      end else begin
         c_s = $signed({1'b0, c_mag});
      end
      t_s = 18'sd32640 + c_s;
      if (t_s < 0) begin
         pixel_in = '0;
      end else if (t_s[17:8] > 10'd255) begin
         pixel_in = 8'd255;
      end else begin
         pixel_in = t_s[15:8];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         quad_ff[0] <= quad_in;
         u_ff       <= u_in;
      end
      if (adv[1]) begin
         quad_ff[1] <= quad_ff[0];
         x2_1_ff    <= x2_in;
      end
      if (adv[2]) begin
         quad_ff[2] <= quad_ff[1];
         x2_ff[2]   <= x2_1_ff;
         acc_ff[2]  <= acc2_in;
      end
      if (adv[3]) begin
         quad_ff[3] <= quad_ff[2];
         x2_ff[3]   <= x2_ff[2];
         acc_ff[3]  <= acc3_in;
      end
      if (adv[4]) begin
         quad_ff[4] <= quad_ff[3];
         x2_ff[4]   <= x2_ff[3];
         acc_ff[4]  <= acc4_in;
      end
      if (adv[5]) begin
         quad_ff[5] <= quad_ff[4];
         acc_ff[5]  <= acc5_in;
      end
      if (adv[6]) begin
         pixel_ff   <= pixel_in;
      end
   end

endmodule

FILE: test/cgp_checker.sv
// Checker for the cosine grating pixel generator: watches channels, predicts and compares.
`timescale 1ns / 1ps

module cgp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   import cgp_pkg::*;

   localparam longint C_ONE = 64'sd1073741824;
   localparam longint C_1   = 64'sd1324675879;
   localparam longint C_2   = 64'sd272375560;
   localparam longint C_3   = 64'sd22401992;
   localparam longint C_4   = 64'sd987048;

   logic [SIZE_W-1:0] size_q;
   logic [FREQ_W-1:0] freq_q;
   logic              orient_q;
   logic [7:0]        pixel_queue[$];

   // quarter-wave cosine in Q30, u in 0..16384
   function automatic longint quarter_wave(input longint u);
      longint x2, acc;
      x2  = u * u * 4;
      acc = C_4;
      acc = C_3 - ((acc * x2) >>> 30);
      acc = C_2 - ((acc * x2) >>> 30);
      acc = C_1 - ((acc * x2) >>> 30);
      if (acc < 0) acc = 0;
      acc = C_ONE - ((acc * x2) >>> 30);
      if (acc < 0) acc = 0;
      if (acc > C_ONE) acc = C_ONE;
      return acc;
   endfunction

   function automatic logic [7:0] grating_pixel(input logic [9:0] row, input logic [9:0] col);
      longint n, idx, phase, frac, u, c, t;
      logic [1:0] quad;
      n = size_q;
      if (n == 0) n = 1;
      if (n > DEF_MAX_SIZE) n = DEF_MAX_SIZE;
      idx   = orient_q ? row : col;
      phase = (freq_q * idx) % n;
      frac  = (((phase << 16) + (n >> 1)) / n) & 16'hFFFF;
      quad  = frac[15:14];
      u     = frac & 16383;
      if (quad[0]) u = 16384 - u;
      c = (quarter_wave(u) + 16384) >>> 15;
      if (c > 32767) c = 32767;
      if (quad == 2'd1 || quad == 2'd2) c = -c;
      t = 32640 + c;
      if (t < 0) t = 0;
      t = t >>> 8;
      if (t > 255) t = 255;
      return t[7:0];
   endfunction

   assign pending = pixel_queue.size();

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         size_q     <= SIZE_RESET;
         freq_q     <= FREQ_RESET;
         orient_q   <= 1'b0;
         fail_count <= 0;
         pixel_queue.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_SIZE:   size_q   <= csr_pwdata[SIZE_W-1:0];
               REG_FREQ:   freq_q   <= csr_pwdata[FREQ_W-1:0];
               REG_ORIENT: orient_q <= csr_pwdata[0];
               default: ;
            endcase
         end
         // accepted coordinate
         if (req_tvalid && req_tready)
            pixel_queue.push_back(grating_pixel(req_tdata[9:0], req_tdata[19:10]));
         // accepted pixel
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_queue.size() == 0) begin
               $error("unexpected item: pixel actual %0d", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_queue.pop_front();
               if (want !== rsp_tdata) begin
                  $error("pixel mismatch: expected %0d actual %0d", want, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: test/testbench.sv
// Stimulus and verdict for the cosine grating pixel generator.
`timescale 1ns / 1ps

module testbench;
   import cgp_pkg::*;

   localparam int LATENCY    = 54;
   localparam int IDLE_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   bit          hold_off = 1'b0;
   int          gap_left = 0;
   int          burst_left = 0;
   logic [10:0] cur_size = 11'd256;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cosine_grating_pixel u_top (.*);

   cgp_checker u_checker (.*);

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // receiver stall pattern, with one long hold-off
   always @(negedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 9) < 7);
   end

   task automatic drain();
      if (req_tvalid) req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   // register writes only with the block empty
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      drain();
      csr_psel <= 1'b1; csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00}; csr_pwdata <= value;
      @(negedge clock) csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(negedge clock);
      if (index == REG_SIZE) cur_size = value[10:0];
   endtask

   // send one coordinate, with bursts and gaps
   task automatic send_coord(input logic [9:0] row, input logic [9:0] col);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (gap_left > 0) req_tvalid <= 1'b0;
         repeat (gap_left) @(negedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, col, row};
      @(posedge clock iff req_tready);
      @(negedge clock);
   endtask

   function automatic logic [9:0] coord_in_image();
      int lim;
      lim = (cur_size == 0) ? 1 : (cur_size > 1024 ? 1024 : cur_size);
      if ($urandom_range(0, 19) == 0) return 10'($urandom_range(0, 1023));
      return 10'($urandom_range(0, lim - 1));
   endfunction

   task automatic random_phase(input int count);
      repeat (count) send_coord(coord_in_image(), coord_in_image());
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset setting, field extremes
      send_coord(10'd0, 10'd0);
      send_coord(10'd1023, 10'd1023);
      send_coord(10'd0, 10'd64);
      send_coord(10'd0, 10'd128);
      send_coord(10'd0, 10'd192);
      send_coord(10'h155, 10'h2AA);
      send_coord(10'h2AA, 10'h155);
      drain();
      // size zero, frequency zero, oversize, largest frequency
      csr_write(REG_SIZE, 0);
      send_coord(10'd5, 10'd7);
      csr_write(REG_SIZE, 2047);
      csr_write(REG_FREQ, 0);
      send_coord(10'd3, 10'd1000);
      csr_write(REG_FREQ, 511);
      csr_write(REG_ORIENT, 1);
      send_coord(10'd1023, 10'd0);
      send_coord(10'd513, 10'd1);
      csr_write(REG_SIZE, 1024);
      csr_write(REG_FREQ, 256);
      send_coord(10'd1, 10'd2);
      send_coord(10'd1023, 10'd1023);
      drain();

      // random settings, extremes among them
      for (int ph = 0; ph < 12; ph++) begin
         csr_write(REG_SIZE, (ph == 0) ? 1 : (ph == 1) ? 1024 : (ph == 2) ? 2
                             : $urandom_range(0, 2047));
         csr_write(REG_FREQ, (ph == 0) ? 1 : (ph == 1) ? 256
                             : $urandom_range(0, 511));
         csr_write(REG_ORIENT, $urandom_range(0, 1));
         if (ph == 4) begin
            // long receiver hold-off while coordinates keep coming
            fork
               begin
                  hold_off = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_off = 1'b0;
               end
               random_phase(120);
            join
         end else
            random_phase(125);
         drain();
      end

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
